// ===== design/bgf_pkg.sv =====
package bgf_pkg;

  localparam int CELL_W    = 16;
  localparam int FLUX_W    = 18;
  localparam int INVDX_W   = 32;
  localparam int RATE_W    = 32;
  localparam int MUL_A_W   = 18;
  localparam int MUL_B_W   = 32;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam int MIN_CELLS       = 3;
  localparam int CELL_COUNT_RST  = 64;
  localparam int INV_DX_RST      = 65536;
  localparam int MID_DEPTH_DEF   = 2;
  localparam int OUT_DEPTH_DEF   = 4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_CELL_COUNT = cfg_idx_t'(0);
  localparam cfg_idx_t REG_INV_DX     = cfg_idx_t'(1);

  typedef enum logic [1:0] {
    KIND_FIRST,
    KIND_SECOND,
    KIND_BODY
  } kind_t;

  typedef enum logic [1:0] {
    BK_SQ,
    BK_FACE,
    BK_MUL,
    BK_DIFF
  } bk_state_t;

  // one classified cell handed from front to back
  typedef struct packed {
    logic signed [CELL_W-1:0] u;
    logic signed [CELL_W-1:0] prev_u;
    logic signed [CELL_W-1:0] first_u;
    logic [CELL_W-1:0]        idx;
    kind_t                    kind;
    logic                     last;
    logic [CELL_W-1:0]        max_abs;
  } entry_t;

  typedef struct packed {
    logic [CELL_W-1:0]        cell_index;
    logic signed [RATE_W-1:0] rate;
    logic [CELL_W-1:0]        max_abs_value;
    logic                     last;
  } res_t;

  function automatic logic [CELL_W-1:0] mag16(input logic signed [CELL_W-1:0] v);
    logic [CELL_W-1:0] r;
    r = v[CELL_W-1] ? CELL_W'(-v) : CELL_W'(v);
    return r;
  endfunction

  // Godunov flux for u^2/2 given both values and their half squares
  function automatic logic [FLUX_W-1:0] face_flux(
    input logic signed [CELL_W-1:0] ul,
    input logic signed [CELL_W-1:0] ur,
    input logic [FLUX_W-1:0]        fl,
    input logic [FLUX_W-1:0]        fr
  );
    logic same;
    logic [FLUX_W-1:0] r;
    same = (ul > 0 && ur > 0) || (ul < 0 && ur < 0);
    if (ul <= ur) begin
      if (same) r = (fl < fr) ? fl : fr;
      else      r = '0;
    end else begin
      r = (fl > fr) ? fl : fr;
    end
    return r;
  endfunction

endpackage

// ===== design/burgers_godunov_flux_stencil.sv =====
// Each cell is squared and its rates are scaled on the back end's single shared
// multiplier, used once for the square and once per emitted rate. The first two cells
// of a pass emit no rate, each interior cell one and the last cell three; the back end
// takes a new cell only once the previous one is done, and waits for result queue room.
// Reset (rst_n low, synchronous) empties both queues, clears the stencil state
// and loads cell_count = 64, inv_dx = 1.0.
module burgers_godunov_flux_stencil #(
  parameter int MID_DEPTH = bgf_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = bgf_pkg::OUT_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic signed [bgf_pkg::CELL_W-1:0]  in_cell_value,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [bgf_pkg::CELL_W-1:0]         out_cell_index,
  output logic signed [bgf_pkg::RATE_W-1:0]  out_rate,
  output logic [bgf_pkg::CELL_W-1:0]         out_max_abs_value,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [bgf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bgf_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import bgf_pkg::*;

  localparam int ENT_W = $bits(entry_t);
  localparam int RES_W = $bits(res_t);

  logic [CELL_W-1:0]  cell_count_r;
  logic [INVDX_W-1:0] inv_dx_r;

  logic               mid_full, mid_push, mid_empty, mid_pop;
  entry_t             mid_entry, mid_head;
  logic [ENT_W-1:0]   mid_dout;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_level;

  logic               res_push, res_full;
  res_t               res_in, res_head;
  logic [RES_W-1:0]   res_dout;
  logic [$clog2(OUT_DEPTH+1)-1:0] res_level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_count_r <= CELL_W'(CELL_COUNT_RST);
      inv_dx_r     <= INVDX_W'(INV_DX_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELL_COUNT: cell_count_r <= cfg_data[CELL_W-1:0];
        REG_INV_DX:     inv_dx_r     <= cfg_data[INVDX_W-1:0];
        default: ;
      endcase
    end
  end

  bgf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_cell_value (in_cell_value),
    .cell_count    (cell_count_r),
    .mid_full      (mid_full),
    .mid_push      (mid_push),
    .mid_entry     (mid_entry)
  );

  bgf_fifo #(.WIDTH(ENT_W), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .din   (mid_entry),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .empty (mid_empty),
    .level (mid_level)
  );

  assign mid_head = entry_t'(mid_dout);

  bgf_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .inv_dx    (inv_dx_r),
    .mid_empty (mid_empty || (mid_level == '0)),
    .mid_head  (mid_head),
    .mid_pop   (mid_pop),
    .out_level (res_level),
    .out_push  (res_push),
    .out_item  (res_in)
  );

  bgf_fifo #(.WIDTH(RES_W), .DEPTH(OUT_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_dout),
    .empty (out_empty),
    .level (res_level)
  );

  // back end only issues a rate when the result queue has room
  assign res_head          = res_t'(res_dout);
  assign out_cell_index    = res_head.cell_index;
  assign out_rate          = res_full ? res_head.rate : res_head.rate;
  assign out_max_abs_value = res_head.max_abs_value;
  assign out_last          = res_head.last;

endmodule

// ===== design/bgf_fifo.sv =====
module bgf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == LW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign level   = cnt_r;
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== design/bgf_front.sv =====
module bgf_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic signed [bgf_pkg::CELL_W-1:0] in_cell_value,
  input  logic [bgf_pkg::CELL_W-1:0]     cell_count,
  input  logic                           mid_full,
  output logic                           mid_push,
  output bgf_pkg::entry_t                mid_entry
);
  import bgf_pkg::*;

  logic signed [CELL_W-1:0] first_r, first_nxt;
  logic signed [CELL_W-1:0] prev_r, prev_nxt;
  logic [CELL_W-1:0]        seen_r, seen_nxt;
  logic [CELL_W-1:0]        max_r, max_nxt;

  logic              acc;
  logic [CELL_W-1:0] n_cells;
  logic [CELL_W-1:0] a;
  logic              is_last;

  assign in_full  = mid_full;
  assign acc      = in_push && !mid_full;
  assign mid_push = acc;

  always_comb begin
    n_cells = (cell_count < CELL_W'(MIN_CELLS)) ? CELL_W'(MIN_CELLS) : cell_count;
    a       = mag16(in_cell_value);
    // seen == 1 never qualifies since the mesh has at least three cells
    is_last = (seen_r != '0) && (seen_r >= n_cells - 1'b1);

    if (seen_r == '0)  max_nxt = a;
    else if (a > max_r) max_nxt = a;
    else               max_nxt = max_r;

    first_nxt = (seen_r == '0) ? in_cell_value : first_r;
    prev_nxt  = in_cell_value;
    seen_nxt  = is_last ? '0 : seen_r + 1'b1;

    mid_entry.u       = in_cell_value;
    mid_entry.prev_u  = prev_r;
    mid_entry.first_u = first_r;
    mid_entry.idx     = seen_r;
    mid_entry.last    = is_last;
    mid_entry.max_abs = max_nxt;
    case (seen_r)
      CELL_W'(0): mid_entry.kind = KIND_FIRST;
      CELL_W'(1): mid_entry.kind = KIND_SECOND;
      default:    mid_entry.kind = KIND_BODY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      prev_r  <= '0;
      seen_r  <= '0;
      max_r   <= '0;
    end else if (acc) begin
      first_r <= first_nxt;
      prev_r  <= prev_nxt;
      seen_r  <= seen_nxt;
      max_r   <= max_nxt;
    end
  end

endmodule

// ===== design/bgf_back.sv =====
module bgf_back #(
  parameter int OUT_DEPTH = bgf_pkg::OUT_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [bgf_pkg::INVDX_W-1:0]        inv_dx,
  input  logic                               mid_empty,
  input  bgf_pkg::entry_t                    mid_head,
  output logic                               mid_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_level,
  output logic                               out_push,
  output bgf_pkg::res_t                      out_item
);
  import bgf_pkg::*;

  localparam int LW = $clog2(OUT_DEPTH+1);
  localparam int SUM_W = PROD_W + 1;

  bk_state_t st_r, st_nxt;

  entry_t              ent_r;
  logic [PROD_W-1:0]   prod_r;
  logic [FLUX_W-1:0]   prev_hs_r, first_hs_r, prev_face_r, first_face_r, wrap_r;
  logic [FLUX_W-1:0]   mag_r;
  logic                neg_r;
  logic [1:0]          step_r;
  logic                pend_r;
  logic                pend_neg_r;
  logic [CELL_W-1:0]   pend_idx_r, pend_max_r;
  logic                pend_last_r;

  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic                space;
  logic                mul_go;
  logic [FLUX_W-1:0]   hs, face, wrap;
  logic [FLUX_W-1:0]   d_left, d_right;
  logic [CELL_W-1:0]   sq_mag;
  logic [SUM_W-1:0]    rsum;
  logic [SUM_W-17:0]   rq;
  logic [RATE_W-1:0]   rate_v;

  assign mul_p = mul_a * mul_b;

  // half square of the value squared last cycle, round half up
  assign hs   = FLUX_W'((prod_r[31:0] + 32'd4096) >> 13);
  assign face = face_flux(ent_r.prev_u, ent_r.u, prev_hs_r, hs);
  assign wrap = face_flux(ent_r.u, ent_r.first_u, hs, first_hs_r);

  assign space = ({1'b0, out_level} + (LW+1)'(pend_r) + 1'b1) <= (LW+1)'(OUT_DEPTH);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_SQ:   if (!mid_empty) st_nxt = BK_FACE;
      BK_FACE: st_nxt = (ent_r.kind == KIND_BODY) ? BK_MUL : BK_SQ;
      BK_MUL: begin
        if (space) st_nxt = (ent_r.last && step_r != 2'd2) ? BK_DIFF : BK_SQ;
      end
      BK_DIFF: st_nxt = BK_MUL;
      default: st_nxt = BK_SQ;
    endcase
  end

  // outputs and operand selection
  always_comb begin
    mid_pop = 1'b0;
    mul_go  = 1'b0;
    sq_mag  = mag16(mid_head.u);
    mul_a   = {{(MUL_A_W-CELL_W){1'b0}}, sq_mag};
    mul_b   = {{(MUL_B_W-CELL_W){1'b0}}, sq_mag};
    case (st_r)
      BK_SQ:   mid_pop = !mid_empty;
      BK_MUL: begin
        mul_a  = mag_r;
        mul_b  = inv_dx;
        mul_go = space;
      end
      default: ;
    endcase
    if (st_r == BK_DIFF && step_r == 2'd2) begin
      d_left  = wrap_r;
      d_right = first_face_r;
    end else if (st_r == BK_DIFF) begin
      d_left  = prev_face_r;
      d_right = wrap_r;
    end else begin
      d_left  = prev_face_r;
      d_right = face;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BK_SQ;
      pend_r <= 1'b0;
      prev_hs_r    <= '0;
      first_hs_r   <= '0;
      prev_face_r  <= '0;
      first_face_r <= '0;
      step_r <= '0;
    end else begin
      st_r   <= st_nxt;
      pend_r <= mul_go;
      case (st_r)
        BK_FACE: begin
          case (ent_r.kind)
            KIND_FIRST: begin
              first_hs_r <= hs;
              prev_hs_r  <= hs;
            end
            KIND_SECOND: begin
              first_face_r <= face;
              prev_face_r  <= face;
              prev_hs_r    <= hs;
            end
            default: begin
              prev_face_r <= face;
              prev_hs_r   <= hs;
            end
          endcase
          step_r <= '0;
        end
        BK_MUL:  if (mul_go) step_r <= step_r + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      ent_r  <= mid_head;
      prod_r <= mul_p;
    end
    if (mul_go) begin
      prod_r      <= mul_p;
      pend_neg_r  <= neg_r;
      pend_last_r <= (step_r == 2'd2);
      pend_max_r  <= (step_r == 2'd2) ? ent_r.max_abs : '0;
      case (step_r)
        2'd0:    pend_idx_r <= ent_r.idx - 1'b1;
        2'd1:    pend_idx_r <= ent_r.idx;
        default: pend_idx_r <= '0;
      endcase
    end
    if (st_r == BK_FACE) begin
      wrap_r <= wrap;
    end
    if (st_r == BK_FACE || st_r == BK_DIFF) begin
      neg_r <= d_right > d_left;
      mag_r <= (d_right > d_left) ? d_right - d_left : d_left - d_right;
    end
  end

  // round half away from zero, then saturate
  always_comb begin
    rsum = {1'b0, prod_r} + SUM_W'(32768);
    rq   = rsum[SUM_W-1:16];
    if (pend_neg_r) begin
      if (rq > (SUM_W-16)'(33'h080000000)) rate_v = 32'h80000000;
      else                                 rate_v = RATE_W'(-rq);
    end else begin
      if (rq > (SUM_W-16)'(33'h07FFFFFFF)) rate_v = 32'h7FFFFFFF;
      else                                 rate_v = RATE_W'(rq);
    end
    out_push               = pend_r;
    out_item.cell_index    = pend_idx_r;
    out_item.rate          = rate_v;
    out_item.max_abs_value = pend_max_r;
    out_item.last          = pend_last_r;
  end

endmodule

// ===== tb/bgf_flux_checker.sv =====
module bgf_flux_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  logic                              in_full,
  input  logic signed [bgf_pkg::CELL_W-1:0] in_cell_value,
  input  logic                              out_empty,
  input  logic                              out_pop,
  input  logic [bgf_pkg::CELL_W-1:0]        out_cell_index,
  input  logic signed [bgf_pkg::RATE_W-1:0] out_rate,
  input  logic [bgf_pkg::CELL_W-1:0]        out_max_abs_value,
  input  logic                              out_last,
  input  logic                              cfg_we,
  input  logic [bgf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bgf_pkg::CFG_DAT_W-1:0]     cfg_data,
  output int                                fail_count,
  output int                                waiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import bgf_pkg::*;

  // configuration copy, taken from the write port
  logic [CELL_W-1:0]  mesh_cells;
  logic [INVDX_W-1:0] inv_width;

  // stencil state
  logic signed [CELL_W-1:0] u_first;
  logic signed [CELL_W-1:0] u_prev;
  logic [FLUX_W-1:0]        flux_first;
  logic [FLUX_W-1:0]        flux_prev;
  logic [CELL_W-1:0]        cells_taken;
  logic [CELL_W-1:0]        peak_abs;

  res_t expected_rates[$];
  res_t want;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [CELL_W-1:0] abs_u(input logic signed [CELL_W-1:0] u);
    return (u < 0) ? CELL_W'(0 - u) : CELL_W'(u);
  endfunction

  // u^2/2 in Q6.12, round half up
  function automatic logic [FLUX_W-1:0] u_sq_half(input logic signed [CELL_W-1:0] u);
    int unsigned m;
    m = abs_u(u);
    return FLUX_W'((m * m + 32'd4096) >> 13);
  endfunction

  function automatic logic [FLUX_W-1:0] godunov_face(input logic signed [CELL_W-1:0] ul,
                                                     input logic signed [CELL_W-1:0] ur);
    logic [FLUX_W-1:0] fl, fr;
    fl = u_sq_half(ul);
    fr = u_sq_half(ur);
    if (ul > ur) return (fl > fr) ? fl : fr;
    if ((ul > 0 && ur > 0) || (ul < 0 && ur < 0)) return (fl < fr) ? fl : fr;
    return '0;
  endfunction

  // (left - right) * inv_dx, >> 16 rounding away from zero, saturated
  function automatic logic signed [RATE_W-1:0] rate_of(input logic [FLUX_W-1:0] left,
                                                       input logic [FLUX_W-1:0] right);
    logic        neg;
    logic [63:0] p;
    neg = right > left;
    p = 64'(neg ? right - left : left - right);
    p = (p * 64'(inv_width) + 64'd32768) >> 16;
    if (neg) begin
      if (p > 64'h8000_0000) p = 64'h8000_0000;
      return RATE_W'(64'd0 - p);
    end
    if (p > 64'h7FFF_FFFF) p = 64'h7FFF_FFFF;
    return RATE_W'(p);
  endfunction

  function automatic void queue_rate(input int unsigned idx, input logic signed [RATE_W-1:0] r,
                                     input logic [CELL_W-1:0] peak, input logic fin);
    res_t e;
    e.cell_index    = CELL_W'(idx);
    e.rate          = r;
    e.max_abs_value = peak;
    e.last          = fin;
    expected_rates.push_back(e);
  endfunction

  function automatic void take_cell(input logic signed [CELL_W-1:0] u);
    int unsigned       n, k;
    logic [CELL_W-1:0] a;
    logic [FLUX_W-1:0] face, wrap;
    n = (mesh_cells < MIN_CELLS) ? MIN_CELLS : mesh_cells;
    k = cells_taken;
    a = abs_u(u);
    if (k == 0) begin
      u_first     = u;
      u_prev      = u;
      peak_abs    = a;
      cells_taken = 1;
      return;
    end
    if (a > peak_abs) peak_abs = a;
    face = godunov_face(u_prev, u);
    if (k == 1) flux_first = face;
    else queue_rate(k - 1, rate_of(flux_prev, face), '0, 1'b0);
    flux_prev = face;
    u_prev    = u;
    if (k >= n - 1) begin
      // last cell of the pass: close it with the wrap face, then cell 0
      wrap = godunov_face(u, u_first);
      queue_rate(k, rate_of(flux_prev, wrap), '0, 1'b0);
      queue_rate(0, rate_of(wrap, flux_first), peak_abs, 1'b1);
      cells_taken = '0;
    end else begin
      cells_taken = CELL_W'(k + 1);
    end
  endfunction

  initial begin
    fail_count = 0;
    waiting    = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      mesh_cells  = CELL_W'(CELL_COUNT_RST);
      inv_width   = INVDX_W'(INV_DX_RST);
      u_first     = '0;
      u_prev      = '0;
      flux_first  = '0;
      flux_prev   = '0;
      cells_taken = '0;
      peak_abs    = '0;
      expected_rates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CELL_COUNT: mesh_cells = cfg_data[CELL_W-1:0];
          REG_INV_DX:     inv_width  = cfg_data[INVDX_W-1:0];
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        if (expected_rates.size() == 0) begin
          report_mismatch($sformatf("unexpected item: cell %0d rate %0d",
                                    out_cell_index, out_rate));
        end else begin
          want = expected_rates.pop_front();
          if (out_cell_index !== want.cell_index)
            report_mismatch($sformatf("cell_index: expected %0d got %0d",
                                      want.cell_index, out_cell_index));
          if (out_rate !== want.rate)
            report_mismatch($sformatf("rate of cell %0d: expected %0d got %0d",
                                      want.cell_index, want.rate, out_rate));
          if (out_max_abs_value !== want.max_abs_value)
            report_mismatch($sformatf("max_abs_value of cell %0d: expected %0d got %0d",
                                      want.cell_index, want.max_abs_value,
                                      out_max_abs_value));
          if (out_last !== want.last)
            report_mismatch($sformatf("last of cell %0d: expected %0b got %0b",
                                      want.cell_index, want.last, out_last));
        end
      end
      if (in_push && !in_full) take_cell(in_cell_value);
    end
    waiting = expected_rates.size();
  end

endmodule

// ===== tb/tb_burgers_godunov_flux_stencil.sv =====
module tb_burgers_godunov_flux_stencil;
  timeunit 1ns;
  timeprecision 1ps;
  import bgf_pkg::*;

  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 200;
  localparam int DEAD_LIMIT    = 4000;
  localparam int PHASES        = 12;
  localparam int PHASE_CELLS   = 26;

  logic                     clk;
  logic                     rst_n;
  logic                     in_push;
  logic                     in_full;
  logic signed [CELL_W-1:0] in_cell_value;
  logic                     out_empty;
  logic                     out_pop;
  logic [CELL_W-1:0]        out_cell_index;
  logic signed [RATE_W-1:0] out_rate;
  logic [CELL_W-1:0]        out_max_abs_value;
  logic                     out_last;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DAT_W-1:0]     cfg_data;

  int fail_count;
  int waiting;
  int send_idle_pct;
  int recv_idle_pct;
  int holds_asked;
  int holds_done;
  int dead_cycles;
  logic signed [CELL_W-1:0] walk;

  burgers_godunov_flux_stencil dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_cell_value     (in_cell_value),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_cell_index    (out_cell_index),
    .out_rate          (out_rate),
    .out_max_abs_value (out_max_abs_value),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  bgf_flux_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_cell_value     (in_cell_value),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_cell_index    (out_cell_index),
    .out_rate          (out_rate),
    .out_max_abs_value (out_max_abs_value),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .waiting           (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ends the run when no item moves on either side for too long
  initial begin
    dead_cycles = 0;
    while (dead_cycles < DEAD_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) dead_cycles = 0;
      else dead_cycles++;
    end
    $display("burgers_godunov_flux_stencil regression: fail");
    $finish;
  end

  // result side: random pops, plus long hold-offs on request
  initial begin
    out_pop    = 1'b0;
    holds_done = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        out_pop <= 1'b0;
        for (int c = 1; c < HOLD_CYCLES; c++) @(negedge clk);
        holds_done++;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_cell(input logic signed [CELL_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push       <= 1'b1;
    in_cell_value <= v;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  task automatic drain_block();
    in_push <= 1'b0;
    while (waiting != 0) @(negedge clk);
    // first cells of a pass give no item but may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] data);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [CELL_W-1:0] pick_cell();
    case ($urandom_range(7))
      0: walk = CELL_W'($urandom);
      1: begin
        case ($urandom_range(4))
          0:       walk = -16'sd32768;
          1:       walk = 16'sd32767;
          2:       walk = '0;
          3:       walk = 16'sd1;
          default: walk = -16'sd1;
        endcase
      end
      2: walk = CELL_W'($urandom_range(128)) - 16'sd64;
      3: walk = CELL_W'($urandom_range(32767));
      4: walk = CELL_W'(0 - $urandom_range(32768));
      // smooth profile with occasional wrap-around jumps
      default: walk = walk + CELL_W'($urandom_range(2048)) - 16'sd1024;
    endcase
    return walk;
  endfunction

  initial begin
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_cell_value = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    holds_asked   = 0;
    walk          = '0;
    send_idle_pct = 29;
    recv_idle_pct = 83;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // three-cell meshes: extreme values, sign mixes, rising and falling
    write_reg(REG_CELL_COUNT, 3);
    write_reg(REG_INV_DX, 32'h0001_0000);
    send_cell(16'sd32767);  send_cell(-16'sd32768); send_cell(16'sd32767);
    send_cell(-16'sd32768); send_cell(-16'sd32768); send_cell(-16'sd32768);
    send_cell(16'sd4096);   send_cell(16'sd8192);   send_cell(16'sd12288);
    send_cell(-16'sd12288); send_cell(-16'sd4096);  send_cell(16'sd0);
    // rate overflow both ways
    write_reg(REG_INV_DX, 32'hFFFF_FFFF);
    send_cell(16'sd32767);  send_cell(-16'sd32768); send_cell(16'sd1);
    write_reg(REG_INV_DX, 32'h0);
    send_cell(-16'sd1);     send_cell(16'sd20000);  send_cell(-16'sd20000);
    // cell_count below three
    write_reg(REG_CELL_COUNT, 0);
    write_reg(REG_INV_DX, 32'h0001_0000);
    send_cell(16'sd100);    send_cell(-16'sd100);   send_cell(16'sd3000);
    // mesh shrunk in the middle of a pass
    write_reg(REG_CELL_COUNT, 8);
    send_cell(16'sd1000);   send_cell(-16'sd2000);  send_cell(16'sd3000);
    send_cell(16'sd0);
    write_reg(REG_CELL_COUNT, 3);
    send_cell(-16'sd1);

    for (int p = 0; p < PHASES; p++) begin
      case (p % 6)
        0:       write_reg(REG_CELL_COUNT, $urandom_range(2));
        1:       write_reg(REG_CELL_COUNT, 3);
        2:       write_reg(REG_CELL_COUNT, $urandom_range(12, 4));
        3:       write_reg(REG_CELL_COUNT, 65535);
        4:       write_reg(REG_CELL_COUNT, $urandom_range(64, 13));
        default: write_reg(REG_CELL_COUNT, $urandom_range(8, 4));
      endcase
      case (p % 4)
        0:       write_reg(REG_INV_DX, 32'h0001_0000);
        1:       write_reg(REG_INV_DX, 32'hFFFF_FFFF);
        2:       write_reg(REG_INV_DX, 32'h1);
        default: write_reg(REG_INV_DX, $urandom);
      endcase
      if (p < 4) begin
        send_idle_pct = 29;
        recv_idle_pct = 83;
      end else if (p < 8) begin
        send_idle_pct = 83;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // back-pressure: result side stops while cells keep coming
      if (p == 8 || p == 11) holds_asked++;
      for (int i = 0; i < PHASE_CELLS; i++) send_cell(pick_cell());
    end

    in_push <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("burgers_godunov_flux_stencil regression: pass");
    else
      $display("burgers_godunov_flux_stencil regression: fail");
    $finish;
  end

endmodule
